// ===== hdl/rtpg_pkg.sv =====
// Package for the triple parity generator: widths, constants, types and GF(2^8) helpers.
package rtpg_pkg;

  // Lane and word geometry
  localparam int LANES      = 8;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 64;
  localparam int COUNT_W    = 8;

  // Queue between front and back
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // GF(2^8) constants: polynomial 0x11d, its halving constant, low-seven mask
  localparam logic [BYTE_W-1:0] GF_POLY_LO = 8'h1d;
  localparam logic [BYTE_W-1:0] GF_INV_2   = 8'h8e;
  localparam logic [BYTE_W-1:0] LOW7_MASK  = 8'h7f;

  // One classified disk item as it travels through the queue
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              first;
    logic              last;
    logic              buf_end;
  } rtpg_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } rtpg_qstat_t;

  // Multiply one byte by 2 in GF(2^8)
  function automatic logic [BYTE_W-1:0] gf_mul2(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] s;
    s = {b[BYTE_W-2:0], 1'b0};
    if (b[BYTE_W-1]) begin
      s = s ^ GF_POLY_LO;
    end
    return s;
  endfunction

  // Multiply one byte by 2^-1 in GF(2^8)
  function automatic logic [BYTE_W-1:0] gf_div2(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] s;
    s = {1'b0, b[BYTE_W-1:1]} & LOW7_MASK;
    if (b[0]) begin
      s = s ^ GF_INV_2;
    end
    return s;
  endfunction

endpackage

// ===== hdl/rtpg_in_if.sv =====
// Input channel: one disk's byte lanes per transfer, valid/ready handshake.
interface rtpg_in_if;
  import rtpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_lanes;
  logic              buffer_end;

  modport source (output valid, output data_lanes, output buffer_end, input ready);
  modport sink   (input valid, input data_lanes, input buffer_end, output ready);
endinterface

// ===== hdl/rtpg_out_if.sv =====
// Result channel: P, Q and R parity of one chunk per transfer, valid/ready handshake.
interface rtpg_out_if;
  import rtpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] p_parity;
  logic [WORD_W-1:0] q_parity;
  logic [WORD_W-1:0] r_parity;
  logic              last_chunk;

  modport source (output valid, output p_parity, output q_parity, output r_parity,
                  output last_chunk, input ready);
  modport sink   (input valid, input p_parity, input q_parity, input r_parity,
                  input last_chunk, output ready);
endinterface

// ===== hdl/raid_triple_parity_gen.sv =====
// Top level of the RAID triple parity (P, Q, R) generator over GF(2^8).
//
// in_chan carries one data disk per transfer: eight byte lanes of one stripe
// chunk, disks in order from the highest down to disk 0, plus buffer_end.
// out_chan carries one result per chunk: P, Q and R parity bytes per lane and
// last_chunk, the buffer_end of the chunk's final disk.
// cfg_wr_en / cfg_wr_data write disk_count (0 is taken as 1); write it only
// while no chunk is open in the pipeline.
// Throughput: one disk item per cycle, sustained while out_chan does not
// stall, set by the shift/XOR Horner step in the back end's accumulators.
// A chunk's final item is written into the 4-entry queue when accepted, then
// popped and loaded into the output register, which then offers the result.
// When out_chan stalls, one result waits in the output register; the back
// end keeps absorbing non-final disks, and in_chan.ready drops only once the
// queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears the accumulators
// and disk counter, drops out_chan.valid and sets disk_count to 1.
module raid_triple_parity_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rtpg_pkg::COUNT_W-1:0]  cfg_wr_data,
  rtpg_in_if.sink                       in_chan,
  rtpg_out_if.source                    out_chan
);
  import rtpg_pkg::*;

  logic               push;
  logic               pop;
  rtpg_entry_t        push_entry;
  rtpg_entry_t        head;
  rtpg_qstat_t        q_stat;
  logic [COUNT_W-1:0] disk_count;

  rtpg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry),
    .disk_count  (disk_count)
  );

  rtpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  rtpg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // Queue can never be both empty and full
  a_q_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full together");

  // With one disk per stripe every item opens and closes its chunk
  a_single_disk: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (disk_count == '0 || disk_count == COUNT_W'(1)))
      |-> (push_entry.first && push_entry.last))
    else $error("single-disk item not tagged first and last");

  // Popping a chunk end always presents a result on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.last) |=> out_chan.valid)
    else $error("chunk end popped without a result");

  // A waiting result is never overwritten by another chunk end
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !(pop && head.last))
    else $error("stalled result overwritten");
`endif

endmodule

// ===== hdl/rtpg_front.sv =====
// Front end: holds disk_count, counts disks of the chunk and tags items first/last.
module rtpg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rtpg_pkg::COUNT_W-1:0]  cfg_wr_data,
  rtpg_in_if.sink                       in_chan,
  input  rtpg_pkg::rtpg_qstat_t         q_stat,
  output logic                          push,
  output rtpg_pkg::rtpg_entry_t         push_entry,
  output logic [rtpg_pkg::COUNT_W-1:0]  disk_count
);
  import rtpg_pkg::*;

  logic [COUNT_W-1:0] disk_count_r, disk_count_nxt;
  logic [COUNT_W-1:0] disks_seen_r, disks_seen_nxt;
  logic [COUNT_W:0]   seen_inc;
  logic [COUNT_W:0]   need;
  logic               is_last;

  // Zero disk count acts as one disk
  assign need     = (disk_count_r == '0) ? (COUNT_W+1)'(1) : {1'b0, disk_count_r};
  assign seen_inc = {1'b0, disks_seen_r} + (COUNT_W+1)'(1);
  assign is_last  = (seen_inc >= need);

  assign in_chan.ready = !q_stat.full;
  assign push          = in_chan.valid && !q_stat.full;

  assign push_entry.data    = in_chan.data_lanes;
  assign push_entry.first   = (disks_seen_r == '0);
  assign push_entry.last    = is_last;
  assign push_entry.buf_end = in_chan.buffer_end;

  assign disk_count = disk_count_r;

  // Next values for register and disk counter
  always_comb begin
    disk_count_nxt = cfg_wr_en ? cfg_wr_data : disk_count_r;
    disks_seen_nxt = disks_seen_r;
    if (push) begin
      disks_seen_nxt = is_last ? '0 : seen_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_count_r <= COUNT_W'(1);
      disks_seen_r <= '0;
    end else begin
      disk_count_r <= disk_count_nxt;
      disks_seen_r <= disks_seen_nxt;
    end
  end

endmodule

// ===== hdl/rtpg_queue.sv =====
// Short queue of classified items between front and back.
module rtpg_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rtpg_pkg::rtpg_entry_t  push_entry,
  input  logic                   pop,
  output rtpg_pkg::rtpg_entry_t  head,
  output rtpg_pkg::rtpg_qstat_t  q_stat
);
  import rtpg_pkg::*;

  rtpg_entry_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/rtpg_back.sv =====
// Back end: per-lane P/Q/R Horner accumulators and the result output register.
module rtpg_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rtpg_pkg::rtpg_entry_t  head,
  input  rtpg_pkg::rtpg_qstat_t  q_stat,
  output logic                   pop,
  rtpg_out_if.source             out_chan
);
  import rtpg_pkg::*;

  logic [WORD_W-1:0] p_acc_r, q_acc_r, r_acc_r;
  logic [WORD_W-1:0] p_nxt, q_nxt, r_nxt;
  logic [WORD_W-1:0] p_out_r, q_out_r, r_out_r;
  logic              last_out_r;
  logic              out_valid_r, out_valid_nxt;
  logic              emit;

  // Pop unless a chunk end would overwrite a result still waiting
  assign pop  = !q_stat.empty && (!head.last || !out_valid_r || out_chan.ready);
  assign emit = pop && head.last;

  // One Horner step per lane; unused lanes stay zero
  for (genvar k = 0; k < WORD_W / BYTE_W; k++) begin : g_lane
    if (k < LANES) begin : g_used
      logic [BYTE_W-1:0] d;
      assign d = head.data[k*BYTE_W +: BYTE_W];
      assign p_nxt[k*BYTE_W +: BYTE_W] = head.first ? d
                                       : (p_acc_r[k*BYTE_W +: BYTE_W] ^ d);
      assign q_nxt[k*BYTE_W +: BYTE_W] = head.first ? d
                                       : (gf_mul2(q_acc_r[k*BYTE_W +: BYTE_W]) ^ d);
      assign r_nxt[k*BYTE_W +: BYTE_W] = head.first ? d
                                       : (gf_div2(r_acc_r[k*BYTE_W +: BYTE_W]) ^ d);
    end else begin : g_unused
      assign p_nxt[k*BYTE_W +: BYTE_W] = '0;
      assign q_nxt[k*BYTE_W +: BYTE_W] = '0;
      assign r_nxt[k*BYTE_W +: BYTE_W] = '0;
    end
  end

  // Output register valid: set on chunk end, cleared on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_acc_r     <= '0;
      q_acc_r     <= '0;
      r_acc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        p_acc_r <= p_nxt;
        q_acc_r <= q_nxt;
        r_acc_r <= r_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      p_out_r    <= p_nxt;
      q_out_r    <= q_nxt;
      r_out_r    <= r_nxt;
      last_out_r <= head.buf_end;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.p_parity   = p_out_r;
  assign out_chan.q_parity   = q_out_r;
  assign out_chan.r_parity   = r_out_r;
  assign out_chan.last_chunk = last_out_r;

endmodule
